/* src/assert_macros.svh */
// assertion helpers shared by the rtl files
// each macro expects clk and rst to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/pli_pkg.sv */
package pli_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;
  localparam int IDX_W  = 4;
  localparam int PROD_W = 2 * DATA_W;

  // item kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // one breakpoint as held in the table memory
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } entry_t;

  // divider status toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* src/pli_table.sv */
module pli_table #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  pli_pkg::entry_t               wdata,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output pli_pkg::entry_t               rdata
);
  import pli_pkg::*;

  entry_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/pli_div.sv */
`include "assert_macros.svh"

module pli_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pli_pkg::PROD_W-1:0]    dividend,
  input  logic [pli_pkg::DATA_W-1:0]    divisor,
  output logic [pli_pkg::DATA_W-1:0]    quotient,
  output pli_pkg::div_status_t          status
);
  import pli_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] low;
  logic [DATA_W-1:0] div;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DATA_W:0]   trial;
  logic              fits;

  // restoring step: shift in one dividend bit, subtract when it fits
  assign trial = {rem, low[DATA_W-1]};
  assign fits  = trial >= {1'b0, div};

  // control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(DATA_W - 1);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: high half starts as the partial remainder, below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[PROD_W-1:DATA_W];
      low <= dividend[DATA_W-1:0];
      div <= divisor;
    end else if (busy) begin
      rem <= fits ? DATA_W'(trial - {1'b0, div}) : trial[DATA_W-1:0];
      low <= {low[DATA_W-2:0], fits};
    end
  end

  assign quotient    = low;
  assign status.busy = busy;
  assign status.done = done;

  `ASSERT_NEXT(a_start_busy, start, busy)
  `ASSERT_NEXT(a_last_step_done, busy && cnt == '0 && !start, done && !busy)

endmodule

/* src/piecewise_linear_interpolator.sv */
// piecewise linear interpolation table
//
// input channel (in_valid / in_stall): a load item (mode 0) writes one
// breakpoint pair into the table and gives no result; a query item (mode 1)
// gives one result on the output channel (out_valid / out_stall).
// entries_in_use is set through cfg_we / cfg_wdata; the user must write it only
// while the block idles, as the block itself does not enforce this.
// a load writes the table on its transfer; the next item can follow at once.
// a query reads entries 0 and 1 to find the table order, then scans the n
// entries in use (one table read per cycle), sets up the differences,
// multiplies, runs the bit-serial divide and loads the output register;
// the next item is taken once the result is in the output register.
// queries that end without interpolation finish earlier.
// the table memory's single read port serialises the scan.
//
// the result sits in an output register; the block takes new items while it
// waits. when the receiver stalls with a result pending, the next query holds
// its result until the register frees up.
// reset clears the control state and entries_in_use; table contents stay
// unknown until loaded.
`include "assert_macros.svh"

module piecewise_linear_interpolator #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pli_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [pli_pkg::IDX_W-1:0]         entry_index,
  input  logic signed [pli_pkg::DATA_W-1:0] point_x,
  input  logic signed [pli_pkg::DATA_W-1:0] point_y,
  input  logic signed [pli_pkg::DATA_W-1:0] query_x,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pli_pkg::DATA_W-1:0] estimate,
  output logic                              in_range
);
  import pli_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_PREP = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic signed [DATA_W-1:0] EST_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] EST_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic [2:0]               state;
  logic [CFG_W-1:0]         entries_in_use;
  logic [CNT_W-1:0]         n_eff;
  logic                     acc;
  logic                     out_free;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  entry_t                   mem_wdata;
  logic [ADDR_W-1:0]        mem_raddr;
  entry_t                   mem_rdata;

  logic signed [DATA_W-1:0] q;
  logic signed [DATA_W-1:0] x_first;
  logic                     asc;
  logic [ADDR_W-1:0]        issue_idx;
  logic [CNT_W-1:0]         issue_left;
  logic                     rd_pend;
  logic                     rd_first;
  logic                     rd_last;
  logic                     hit;

  logic signed [DATA_W-1:0] lo_x;
  logic signed [DATA_W-1:0] lo_y;
  logic signed [DATA_W-1:0] hi_x;
  logic signed [DATA_W-1:0] hi_y;
  logic [DATA_W:0]          dx;
  logic [DATA_W:0]          dq;
  logic [DATA_W:0]          dy;
  logic [DATA_W:0]          dy_abs;
  logic                     bad;
  logic [DATA_W-1:0]        mag_dy;
  logic [DATA_W-1:0]        dq_r;
  logic [DATA_W-1:0]        dx_r;
  logic                     dy_neg;

  logic                     div_start;
  logic [PROD_W-1:0]        product;
  logic [DATA_W-1:0]        quo;
  div_status_t              div_st;
  logic [DATA_W+1:0]        step_val;
  logic [DATA_W+1:0]        sum;
  logic signed [DATA_W-1:0] sum_sat;

  logic signed [DATA_W-1:0] res_est;
  logic                     res_ok;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  // breakpoints in use, capped at the table depth
  assign n_eff = (32'(entries_in_use) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(entries_in_use);

  // handshake
  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // table write on a load transfer
  assign mem_we          = acc && (mode == MODE_LOAD) && (32'(entry_index) < TABLE_DEPTH);
  assign mem_waddr       = ADDR_W'(entry_index);
  assign mem_wdata.x     = point_x;
  assign mem_wdata.y     = point_y;

  // read address per state
  always_comb begin
    case (state)
      S_RD0:   mem_raddr = ADDR_W'(1);
      S_SCAN:  mem_raddr = issue_idx;
      default: mem_raddr = '0;
    endcase
  end

  pli_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // scan compare on the entry that just came back
  assign hit = rd_pend && (mem_rdata.x > q);

  // interpolation setup differences
  assign dx     = {hi_x[DATA_W-1], hi_x} - {lo_x[DATA_W-1], lo_x};
  assign dq     = {q[DATA_W-1], q} - {lo_x[DATA_W-1], lo_x};
  assign dy     = {hi_y[DATA_W-1], hi_y} - {lo_y[DATA_W-1], lo_y};
  assign dy_abs = dy[DATA_W] ? -dy : dy;
  assign bad    = dx[DATA_W] || (dx == '0) || dq[DATA_W];

  // multiply feeds the divider's registers directly
  assign product   = PROD_W'(mag_dy) * PROD_W'(dq_r);
  assign div_start = (state == S_MUL);

  pli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (dx_r),
    .quotient (quo),
    .status   (div_st)
  );

  // final sum with saturation
  assign step_val = dy_neg ? -{2'b00, quo} : {2'b00, quo};
  assign sum      = {{2{lo_y[DATA_W-1]}}, lo_y} + step_val;
  always_comb begin
    if (sum[DATA_W+1:DATA_W-1] == 3'b000 || sum[DATA_W+1:DATA_W-1] == 3'b111) begin
      sum_sat = sum[DATA_W-1:0];
    end else if (sum[DATA_W+1]) begin
      sum_sat = EST_MIN;
    end else begin
      sum_sat = EST_MAX;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc && mode == MODE_QUERY) begin
            state <= (n_eff < CNT_W'(2)) ? S_OUT : S_RD0;
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          rd_pend <= 1'b0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          rd_pend <= (issue_left != '0);
          if (rd_pend) begin
            if (hit) begin
              state <= rd_first ? S_OUT : S_PREP;
            end else if (rd_last) begin
              state <= S_OUT;
            end
          end
        end
        S_PREP: begin
          state <= bad ? S_OUT : S_MUL;
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        q       <= query_x;
        res_est <= '0;
        res_ok  <= 1'b0;
      end
      S_RD0: begin
        x_first <= mem_rdata.x;
      end
      S_RD1: begin
        asc        <= x_first < mem_rdata.x;
        issue_idx  <= (x_first < mem_rdata.x) ? '0 : ADDR_W'(n_eff - CNT_W'(1));
        issue_left <= n_eff;
      end
      S_SCAN: begin
        // issue the next read
        if (issue_left != '0) begin
          issue_idx  <= asc ? issue_idx + ADDR_W'(1) : issue_idx - ADDR_W'(1);
          issue_left <= issue_left - CNT_W'(1);
          rd_first   <= (issue_left == n_eff);
          rd_last    <= (issue_left == CNT_W'(1));
        end
        // judge the entry that came back
        if (rd_pend) begin
          if (hit) begin
            hi_x <= mem_rdata.x;
            hi_y <= mem_rdata.y;
            if (rd_first) begin
              res_est <= mem_rdata.y;
              res_ok  <= 1'b1;
            end
          end else begin
            lo_x <= mem_rdata.x;
            lo_y <= mem_rdata.y;
          end
        end
      end
      S_PREP: begin
        mag_dy <= dy_abs[DATA_W-1:0];
        dy_neg <= dy[DATA_W];
        dq_r   <= dq[DATA_W-1:0];
        dx_r   <= dx[DATA_W-1:0];
        if (bad) begin
          res_est <= lo_y;
          res_ok  <= 1'b1;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          res_est <= sum_sat;
          res_ok  <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      estimate <= res_est;
      in_range <= res_ok;
    end
  end

  `ASSERT_NEXT(a_query_busy, acc && mode == MODE_QUERY, in_stall)
  `ASSERT_NEXT(a_load_free, acc && mode == MODE_LOAD, !in_stall)
  `ASSERT_IMP(a_div_done_state, div_st.done, state == S_DIV)
  `ASSERT_IMP(a_div_start_idle, div_start, !div_st.busy)

endmodule
